// ===== src/hsl_saturation_adjust_assert.svh =====
// Assertion macros for the HSL saturation block.
// Used by the top level only; no other dependencies.
`ifndef HSL_SATURATION_ADJUST_ASSERT_SVH
`define HSL_SATURATION_ADJUST_ASSERT_SVH
`ifndef ASSERT_OFF
`define HSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`define HSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define HSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/hsa_pkg.sv =====
// Shared types and constants for the HSL saturation block.
// No dependencies.
`timescale 1ns / 1ps
package hsa_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } res_t;

  localparam int unsigned SETTING_DIVISOR_DEF = 200;
  localparam logic [7:0]  SETTING_RESET       = 8'd100;
  localparam logic [7:0]  SETTING_NEUTRAL     = 8'd100;
  localparam int unsigned FRAC_W              = 16;

  // saturation quotient: Q1.16, up to 1.0
  localparam int unsigned SAT_W      = 17;
  // reciprocal quotient 2^32/m, m >= 257
  localparam int unsigned RECIP_Q_W  = 24;
  localparam logic [17:0] RECIP_REM0 = 18'd256;

endpackage

// ===== src/hsa_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; side data rides along with each beat.
`timescale 1ns / 1ps
module hsa_div_pipe #(
  parameter int unsigned QW = 17,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW:0]   rem_i,
  input  logic [QW-1:0] bits_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [QW];
  logic [DW:0]   rem_q  [QW];
  logic [QW-1:0] bits_q [QW];
  logic [QW-1:0] quot_q [QW];
  logic [DW-1:0] div_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_in;
    logic [DW:0]   rem_in;
    logic [QW-1:0] bits_in;
    logic [QW-1:0] quot_in;
    logic [DW-1:0] div_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   shifted;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rem_i;
      assign bits_in = bits_i;
      assign quot_in = '0;
      assign div_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign bits_in = bits_q[k-1];
      assign quot_in = quot_q[k-1];
      assign div_in  = div_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign shifted = {rem_in[DW-1:0], bits_in[QW-1]};
    assign ge      = shifted >= {1'b0, div_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? (shifted - {1'b0, div_in}) : shifted;
      bits_q[k] <= {bits_in[QW-2:0], 1'b0};
      quot_q[k] <= {quot_in[QW-2:0], ge};
      div_q[k]  <= div_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== src/hsl_saturation_adjust.sv =====
// HSL saturation adjust: one pixel per clock, a result strobe for each start beat.
// Latency is set by two pipelined dividers (17 + 24 stages) plus five datapath stages.
// busy stays low: a new pixel is taken every cycle; results cannot be held off.
// Reset (rst_ni low, async) clears all valid bits and sets the setting to 100.
// Setting writes pass setting_q, incmag_q and alt_q; write only with no pixel in flight.
// Depends on hsa_pkg and hsa_div_pipe.
`timescale 1ns / 1ps
`include "hsl_saturation_adjust_assert.svh"
module hsl_saturation_adjust #(
  parameter int unsigned SETTING_DIVISOR = hsa_pkg::SETTING_DIVISOR_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hsa_pkg::pix_t pix_i,
  output logic          res_valid_o,
  output hsa_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_data_i
);

  localparam int unsigned DIV1_STEPS = hsa_pkg::SAT_W;
  localparam int unsigned DIV2_STEPS = hsa_pkg::RECIP_Q_W;
  localparam int unsigned LATENCY    = 5 + DIV1_STEPS + DIV2_STEPS;

  // inc = d*2^16/DIV via exact reciprocal multiply
  localparam int unsigned         SH_K    = 24 + $clog2(SETTING_DIVISOR);
  localparam int unsigned         RCP_W   = SH_K - $clog2(SETTING_DIVISOR) + 2;
  localparam longint unsigned     RCP_VAL =
    ((64'd1 << SH_K) + SETTING_DIVISOR - 1) / SETTING_DIVISOR;
  localparam logic [RCP_W-1:0]    RCP     = RCP_W'(RCP_VAL);
  localparam int unsigned         RSH     = SH_K - hsa_pkg::FRAC_W;

  typedef struct packed {
    hsa_pkg::pix_t pix;
    logic [8:0]    sum;
    logic          grey;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------- setting and derived constants
  logic [7:0]         setting_q;
  logic [7:0]         dmag;
  logic [RCP_W+7:0]   inc_prod;
  logic [16:0]        incmag_q, incmag_d;
  logic               raise_q;
  logic signed [18:0] alt_q;

  assign dmag     = (setting_q >= hsa_pkg::SETTING_NEUTRAL) ?
                    (setting_q - hsa_pkg::SETTING_NEUTRAL) :
                    (hsa_pkg::SETTING_NEUTRAL - setting_q);
  assign inc_prod = {{RCP_W{1'b0}}, dmag} * {8'd0, RCP};
  assign incmag_d = 17'(inc_prod >> RSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q <= hsa_pkg::SETTING_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      setting_q <= cfg_data_i;
    end
  end

  // 1 - |inc| serves as the floor of m when raising and as the factor when lowering
  always_ff @(posedge clk_i) begin
    incmag_q <= incmag_d;
    raise_q  <= setting_q >= hsa_pkg::SETTING_NEUTRAL;
    alt_q    <= $signed(19'(1 << hsa_pkg::FRAC_W)) - $signed({2'b0, incmag_q});
  end

  // ---------------- stage 0: capture pixel
  logic          v0_q;
  hsa_pkg::pix_t pix0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    pix0_q <= pix_i;
  end

  // ---------------- stage 1: max, min, lightness, denominator
  logic [7:0] mx, mn, den_d;
  logic [8:0] sum_d;
  logic       v1_q;
  logic [7:0] sub_q, den_q;
  side_t      side1_q;

  always_comb begin
    mx = pix0_q.red_in;
    mn = pix0_q.red_in;
    if (pix0_q.green_in > mx) mx = pix0_q.green_in;
    if (pix0_q.green_in < mn) mn = pix0_q.green_in;
    if (pix0_q.blue_in > mx)  mx = pix0_q.blue_in;
    if (pix0_q.blue_in < mn)  mn = pix0_q.blue_in;
    sum_d = {1'b0, mx} + {1'b0, mn};
    den_d = (sum_d < 9'd255) ? sum_d[7:0] : 8'(9'd510 - sum_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sub_q         <= mx - mn;
    den_q         <= den_d;
    side1_q.pix   <= pix0_q;
    side1_q.sum   <= sum_d;
    side1_q.grey  <= mx == mn;
  end

  // ---------------- S = sub * 2^16 / den
  logic              dv1_valid;
  logic [DIV1_STEPS-1:0] sat_q;
  logic [SIDE_W-1:0] dv1_side;

  hsa_div_pipe #(
    .QW(DIV1_STEPS),
    .DW(8),
    .SW(SIDE_W)
  ) u_div_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v1_q),
    .rem_i    ({2'b0, sub_q[7:1]}),
    .bits_i   ({sub_q[0], 16'd0}),
    .divisor_i(den_q),
    .side_i   (SIDE_W'(side1_q)),
    .valid_o  (dv1_valid),
    .quot_o   (sat_q),
    .side_o   (dv1_side)
  );

  // ---------------- stage: m = max(S, 1 - inc)
  logic        v2_q;
  logic [16:0] m_q;
  side_t       side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= dv1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= (alt_q > $signed({2'b0, sat_q})) ? alt_q[16:0] : sat_q;
    side2_q <= side_t'(dv1_side);
  end

  // ---------------- 2^32 / m
  logic              dv2_valid;
  logic [DIV2_STEPS-1:0] rq;
  logic [SIDE_W-1:0] dv2_side;

  hsa_div_pipe #(
    .QW(DIV2_STEPS),
    .DW(17),
    .SW(SIDE_W)
  ) u_div_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v2_q),
    .rem_i    (hsa_pkg::RECIP_REM0),
    .bits_i   ('0),
    .divisor_i(m_q),
    .side_i   (SIDE_W'(side2_q)),
    .valid_o  (dv2_valid),
    .quot_o   (rq),
    .side_o   (dv2_side)
  );

  // ---------------- stage: channel = base + dev * scale
  side_t              side3;
  logic signed [25:0] scale;
  logic [9:0]         base [3];
  logic signed [10:0] dev  [3];
  logic signed [36:0] prod [3];
  logic [7:0]         chv  [3];
  logic               v3_q;
  logic signed [36:0] val_q [3];
  hsa_pkg::pix_t      pix3_q;
  logic               grey3_q;

  assign side3  = side_t'(dv2_side);
  assign chv[0] = side3.pix.red_in;
  assign chv[1] = side3.pix.green_in;
  assign chv[2] = side3.pix.blue_in;
  assign scale  = raise_q ?
                  $signed({2'b0, rq - 24'(1 << hsa_pkg::FRAC_W)}) :
                  26'(alt_q);

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign base[c] = raise_q ? {1'b0, chv[c], 1'b0} : {1'b0, side3.sum};
    assign dev[c]  = $signed({2'b0, chv[c], 1'b0}) - $signed({2'b0, side3.sum});
    assign prod[c] = dev[c] * scale;

    always_ff @(posedge clk_i) begin
      val_q[c] <= prod[c] + $signed(37'({base[c], 16'd0}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= dv2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pix3_q  <= side3.pix;
    grey3_q <= side3.grey;
  end

  // ---------------- stage: truncate, clamp, grey bypass
  logic [7:0]    byte_d [3];
  hsa_pkg::res_t res_d, res_q;
  logic          res_valid_q;

  for (genvar c = 0; c < 3; c++) begin : g_clamp
    always_comb begin
      if (val_q[c] <= 37'sd0) begin
        byte_d[c] = 8'd0;
      end else if (val_q[c][36:17] > 20'd255) begin
        byte_d[c] = 8'd255;
      end else begin
        byte_d[c] = val_q[c][24:17];
      end
    end
  end

  always_comb begin
    if (grey3_q) begin
      res_d = {pix3_q.red_in, pix3_q.green_in, pix3_q.blue_in};
    end else begin
      res_d = {byte_d[0], byte_d[1], byte_d[2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------- checks
  logic in_beat;
  logic grey_beat;

  assign in_beat   = start && !busy;
  assign grey_beat = in_beat && pix_i.red_in == pix_i.green_in &&
                     pix_i.green_in == pix_i.blue_in;

  `HSA_ASSERT_IMP(a_strobe_has_start, clk_i, rst_ni, res_valid_o, $past(in_beat, LATENCY))
  `HSA_ASSERT_IMP(a_start_gives_strobe, clk_i, rst_ni, in_beat, ##LATENCY res_valid_o)
  `HSA_ASSERT_IMP(a_grey, clk_i, rst_ni, $past(grey_beat, LATENCY), res_o == $past(pix_i, LATENCY))

endmodule

// ===== tb/sv/hsl_saturation_adjust_test.sv =====
// Self-checking testbench for hsl_saturation_adjust: drives RGB pixels and
// setting writes, predicts each adjusted pixel and compares. Depends on hsa_pkg.
`timescale 1ns / 1ps
module hsl_saturation_adjust_test;

  localparam int unsigned LATENCY = 46;
  localparam int unsigned DIVISOR = hsa_pkg::SETTING_DIVISOR_DEF;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  hsa_pkg::pix_t pix_i;
  logic          res_valid_o;
  hsa_pkg::res_t res_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [7:0]    cfg_data_i;

  logic [7:0]    setting_q;
  hsa_pkg::res_t pending_pix[$];
  int            err_cnt;

  hsl_saturation_adjust #(.SETTING_DIVISOR(DIVISOR)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .pix_i(pix_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] clamp_byte(longint v);
    longint q;
    if (v <= 0) return 8'd0;
    q = v / 131072;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic hsa_pkg::res_t adjust_pixel(hsa_pkg::pix_t p, logic [7:0] setting);
    longint ch[3];
    longint mx, mn, sum, sub, den, s_q, d, inc_q, m, scale, v;
    hsa_pkg::res_t r;
    logic [7:0] o[3];
    ch[0] = p.red_in; ch[1] = p.green_in; ch[2] = p.blue_in;
    mx = ch[0]; mn = ch[0];
    for (int i = 1; i < 3; i++) begin
      if (ch[i] > mx) mx = ch[i];
      if (ch[i] < mn) mn = ch[i];
    end
    if (mx == mn) begin
      r.red_out = p.red_in; r.green_out = p.green_in; r.blue_out = p.blue_in;
      return r;
    end
    sum = mx + mn;
    sub = mx - mn;
    den = (sum < 255) ? sum : 510 - sum;
    if (den <= 0) den = 1;
    s_q = (sub * 65536) / den;
    d = longint'(setting) - 100;
    inc_q = (d * 65536) / longint'(DIVISOR);
    if (d >= 0) begin
      m = 65536 - inc_q;
      if (s_q > m) m = s_q;
      if (m <= 0) m = 1;
      scale = (64'sd1 <<< 32) / m - 65536;
      for (int i = 0; i < 3; i++) begin
        v = 2 * ch[i] * 65536 + (2 * ch[i] - sum) * scale;
        o[i] = clamp_byte(v);
      end
    end else begin
      scale = 65536 + inc_q;
      for (int i = 0; i < 3; i++) begin
        v = sum * 65536 + (2 * ch[i] - sum) * scale;
        o[i] = clamp_byte(v);
      end
    end
    r.red_out = o[0]; r.green_out = o[1]; r.blue_out = o[2];
    return r;
  endfunction

  // compare each strobed pixel with the oldest prediction
  always @(posedge clk_i) begin
    hsa_pkg::res_t exp_pix;
    if (rst_ni && res_valid_o) begin
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, res_o);
        err_cnt++;
      end else begin
        exp_pix = pending_pix.pop_front();
        if (res_o.red_out !== exp_pix.red_out) begin
          $display("%0t: red expected %0d actual %0d", $time, exp_pix.red_out,
                   res_o.red_out);
          err_cnt++;
        end
        if (res_o.green_out !== exp_pix.green_out) begin
          $display("%0t: green expected %0d actual %0d", $time, exp_pix.green_out,
                   res_o.green_out);
          err_cnt++;
        end
        if (res_o.blue_out !== exp_pix.blue_out) begin
          $display("%0t: blue expected %0d actual %0d", $time, exp_pix.blue_out,
                   res_o.blue_out);
          err_cnt++;
        end
      end
    end
  end

  int burst_left;

  // hold start until accepted; bursts of back-to-back beats with random gaps
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsa_pkg::pix_t p;
    int gap;
    p.red_in = r; p.green_in = g; p.blue_in = b;
    if (burst_left == 0) begin
      gap = int'($urandom_range(0, 6));
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = int'($urandom_range(1, 20));
    end
    burst_left--;
    start <= 1'b1;
    pix_i <= p;
    do @(posedge clk_i); while (busy);
    pending_pix.push_back(adjust_pixel(p, setting_q));
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_pix.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_setting(logic [7:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    setting_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    logic [7:0] base;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          base = 8'($urandom);
          send_pixel(base, base, base);
        end
        1: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0, 8'($urandom),
                      $urandom_range(0, 1) ? 8'd255 : 8'd0);
        2: begin
          base = 8'($urandom);
          send_pixel(base, 8'(base + $urandom_range(0, 3)),
                     8'(base - $urandom_range(0, 3)));
        end
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic test_directed_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd127, 8'd128, 8'd127);
    send_pixel(8'd170, 8'd85, 8'd0);
  endtask

  task automatic test_setting_sweep();
    logic [7:0] settings[9] = '{8'd200, 8'd0, 8'd255, 8'd201, 8'd150, 8'd1, 8'd99,
                                8'd101, 8'd100};
    foreach (settings[k]) begin
      write_setting(settings[k]);
      test_directed_pixels();
      send_random(60);
    end
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 8; k++) begin
      write_setting(8'($urandom));
      send_random(80);
    end
  endtask

  initial begin
    rst_ni = 1'b0; start = 1'b0; pix_i = '0; cfg_valid_i = 1'b0; cfg_data_i = '0;
    setting_q = hsa_pkg::SETTING_RESET; err_cnt = 0; burst_left = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_pixels();
    send_random(40);
    test_setting_sweep();
    test_random_settings();
    drain();
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/hsa_pkg.sv
src/hsa_div_pipe.sv
src/hsl_saturation_adjust.sv
tb/sv/hsl_saturation_adjust_test.sv
